>>> rtl/core/aicd_pkg.sv
`timescale 1ns / 1ps

package aicd_pkg;

  // instruction class codes
  localparam logic [5:0] CLS_BX       = 6'd0;
  localparam logic [5:0] CLS_B        = 6'd1;
  localparam logic [5:0] CLS_BL       = 6'd2;
  localparam logic [5:0] CLS_AND      = 6'd3;
  localparam logic [5:0] CLS_MVN      = 6'd18;
  localparam logic [5:0] CLS_MRS      = 6'd19;
  localparam logic [5:0] CLS_MSR      = 6'd20;
  localparam logic [5:0] CLS_MSR_FLG  = 6'd21;
  localparam logic [5:0] CLS_MUL      = 6'd22;
  localparam logic [5:0] CLS_MLA      = 6'd23;
  localparam logic [5:0] CLS_SMULL    = 6'd24;
  localparam logic [5:0] CLS_SMLAL    = 6'd25;
  localparam logic [5:0] CLS_UMULL    = 6'd26;
  localparam logic [5:0] CLS_UMLAL    = 6'd27;
  localparam logic [5:0] CLS_LDR      = 6'd28;
  localparam logic [5:0] CLS_STR      = 6'd29;
  localparam logic [5:0] CLS_LDRH     = 6'd30;
  localparam logic [5:0] CLS_STRH     = 6'd31;
  localparam logic [5:0] CLS_LDRSB    = 6'd32;
  localparam logic [5:0] CLS_LDRSH    = 6'd33;
  localparam logic [5:0] CLS_LDM      = 6'd34;
  localparam logic [5:0] CLS_STM      = 6'd35;
  localparam logic [5:0] CLS_SWP      = 6'd36;
  localparam logic [5:0] CLS_SWPB     = 6'd37;
  localparam logic [5:0] CLS_SWI      = 6'd38;
  localparam logic [5:0] CLS_CDP      = 6'd39;
  localparam logic [5:0] CLS_LDC      = 6'd40;
  localparam logic [5:0] CLS_STC      = 6'd41;
  localparam logic [5:0] CLS_MRC      = 6'd42;
  localparam logic [5:0] CLS_MCR      = 6'd43;
  localparam logic [5:0] CLS_UNDEF    = 6'd44;
  // table marker, resolved to a data processing opcode afterwards
  localparam logic [5:0] CLS_DATAPROC = 6'd63;

  typedef struct packed {
    logic [31:0] mask;
    logic [31:0] pat;
    logic [5:0]  cls;
  } match_row_t;

  localparam int ROW_COUNT = 31;

  // priority-ordered mask and pattern table, first hit wins
  localparam match_row_t ROWS [ROW_COUNT] = '{
    '{32'h0fff_fff0, 32'h012f_ff10, CLS_BX},
    '{32'h0f00_0000, 32'h0a00_0000, CLS_B},
    '{32'h0f00_0000, 32'h0b00_0000, CLS_BL},
    '{32'h0fe0_00f0, 32'h0000_0090, CLS_MUL},
    '{32'h0fe0_00f0, 32'h0020_0090, CLS_MLA},
    '{32'h0fe0_00f0, 32'h0080_0090, CLS_UMULL},
    '{32'h0fe0_00f0, 32'h00a0_0090, CLS_UMLAL},
    '{32'h0fe0_00f0, 32'h00c0_0090, CLS_SMULL},
    '{32'h0fe0_00f0, 32'h00e0_0090, CLS_SMLAL},
    '{32'h0ff0_0ff0, 32'h0100_0090, CLS_SWP},
    '{32'h0ff0_0ff0, 32'h0140_0090, CLS_SWPB},
    '{32'h0e10_00f0, 32'h0010_00b0, CLS_LDRH},
    '{32'h0e10_00f0, 32'h0000_00b0, CLS_STRH},
    '{32'h0e10_00f0, 32'h0010_00d0, CLS_LDRSB},
    '{32'h0e10_00f0, 32'h0010_00f0, CLS_LDRSH},
    '{32'h0e00_0090, 32'h0000_0090, CLS_UNDEF},
    '{32'h0fbf_0fff, 32'h010f_0000, CLS_MRS},
    '{32'h0fbf_fff0, 32'h0129_f000, CLS_MSR},
    '{32'h0d3f_f000, 32'h0128_f000, CLS_MSR_FLG},
    '{32'h0c00_0000, 32'h0000_0000, CLS_DATAPROC},
    '{32'h0e00_0010, 32'h0600_0010, CLS_UNDEF},
    '{32'h0c10_0000, 32'h0410_0000, CLS_LDR},
    '{32'h0c10_0000, 32'h0400_0000, CLS_STR},
    '{32'h0e10_0000, 32'h0810_0000, CLS_LDM},
    '{32'h0e10_0000, 32'h0800_0000, CLS_STM},
    '{32'h0f00_0000, 32'h0f00_0000, CLS_SWI},
    '{32'h0f00_0010, 32'h0e00_0000, CLS_CDP},
    '{32'h0e10_0000, 32'h0c10_0000, CLS_LDC},
    '{32'h0e10_0000, 32'h0c00_0000, CLS_STC},
    '{32'h0f10_0010, 32'h0e10_0010, CLS_MRC},
    '{32'h0f10_0010, 32'h0e00_0010, CLS_MCR}
  };

  // one decoded result word
  typedef struct packed {
    logic [5:0]  op_class;
    logic [3:0]  cond_code;
    logic [3:0]  dest_reg;
    logic [3:0]  base_reg;
    logic [3:0]  second_reg;
    logic [3:0]  shift_reg;
    logic        set_flags;
    logic [31:0] imm_value;
    logic        reg_operand;
    logic [1:0]  shift_kind;
    logic [4:0]  shift_amount;
    logic [3:0]  mode_bits;
  } dec_t;

endpackage

>>> rtl/core/aicd_in_if.sv
`timescale 1ns / 1ps

interface aicd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instr_word;

  modport source (output valid, output instr_word, input ready);
  modport sink   (input valid, input instr_word, output ready);
endinterface

>>> rtl/core/aicd_out_if.sv
`timescale 1ns / 1ps

interface aicd_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  op_class;
  logic [3:0]  cond_code;
  logic [3:0]  dest_reg;
  logic [3:0]  base_reg;
  logic [3:0]  second_reg;
  logic [3:0]  shift_reg;
  logic        set_flags;
  logic [31:0] imm_value;
  logic        reg_operand;
  logic [1:0]  shift_kind;
  logic [4:0]  shift_amount;
  logic [3:0]  mode_bits;

  modport source (
    output valid, output op_class, output cond_code, output dest_reg, output base_reg,
    output second_reg, output shift_reg, output set_flags, output imm_value,
    output reg_operand, output shift_kind, output shift_amount, output mode_bits,
    input ready
  );
  modport sink (
    input valid, input op_class, input cond_code, input dest_reg, input base_reg,
    input second_reg, input shift_reg, input set_flags, input imm_value,
    input reg_operand, input shift_kind, input shift_amount, input mode_bits,
    output ready
  );
endinterface

>>> rtl/core/arm_instruction_class_decoder.sv
`timescale 1ns / 1ps
// arm instruction class decoder
// a word passes the input register, then the decode, then the result register before the result is valid
// throughput: one word per cycle while results are taken; the decode between the registers is a single pass
// a stalled result holds in the result register; the input register takes one more word
// reset (synchronous, active high) clears both valid flags; payload registers are not reset

module arm_instruction_class_decoder (
  input logic        clk,
  input logic        rst,
  aicd_in_if.sink    inst,
  aicd_out_if.source dec
);

  logic [31:0]    inst_word;
  logic           inst_valid;
  aicd_pkg::dec_t res;
  aicd_pkg::dec_t res_next;
  logic           res_valid;
  logic [5:0]     cls;
  logic           res_ready;
  logic           inst_ready;

  // stage advance
  assign res_ready  = !res_valid || dec.ready;
  assign inst_ready = !inst_valid || res_ready;
  assign inst.ready = inst_ready;

  aicd_classify u_classify (
    .word (inst_word),
    .cls  (cls)
  );

  aicd_fields u_fields (
    .word (inst_word),
    .cls  (cls),
    .dec  (res_next)
  );

  // valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      inst_valid <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (inst_ready) inst_valid <= inst.valid;
      if (res_ready) res_valid <= inst_valid;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (inst.valid && inst_ready) inst_word <= inst.instr_word;
    if (inst_valid && res_ready) res <= res_next;
  end

  // result word out
  assign dec.valid        = res_valid;
  assign dec.op_class     = res.op_class;
  assign dec.cond_code    = res.cond_code;
  assign dec.dest_reg     = res.dest_reg;
  assign dec.base_reg     = res.base_reg;
  assign dec.second_reg   = res.second_reg;
  assign dec.shift_reg    = res.shift_reg;
  assign dec.set_flags    = res.set_flags;
  assign dec.imm_value    = res.imm_value;
  assign dec.reg_operand  = res.reg_operand;
  assign dec.shift_kind   = res.shift_kind;
  assign dec.shift_amount = res.shift_amount;
  assign dec.mode_bits    = res.mode_bits;

endmodule

>>> rtl/core/aicd_classify.sv
`timescale 1ns / 1ps

module aicd_classify (
  input  logic [31:0] word,
  output logic [5:0]  cls
);

  localparam int ROW_HITS_W = aicd_pkg::ROW_COUNT;

  logic [ROW_HITS_W-1:0] hit;
  logic                  found;
  logic [5:0]            row_cls;

  // match every row in parallel
  always_comb begin
    for (int i = 0; i < aicd_pkg::ROW_COUNT; i++) begin
      hit[i] = (word & aicd_pkg::ROWS[i].mask) == aicd_pkg::ROWS[i].pat;
    end
  end

  // first matching row wins
  always_comb begin
    found   = 1'b0;
    row_cls = aicd_pkg::CLS_UNDEF;
    for (int i = 0; i < aicd_pkg::ROW_COUNT; i++) begin
      if (!found && hit[i]) begin
        found   = 1'b1;
        row_cls = aicd_pkg::ROWS[i].cls;
      end
    end
  end

  // data processing opcode, compares without s are undefined
  always_comb begin
    if (row_cls == aicd_pkg::CLS_DATAPROC) begin
      if (word[24:23] == 2'b10 && !word[20]) begin
        cls = aicd_pkg::CLS_UNDEF;
      end else begin
        cls = aicd_pkg::CLS_AND + {2'b00, word[24:21]};
      end
    end else begin
      cls = row_cls;
    end
  end

endmodule

>>> rtl/core/aicd_fields.sv
`timescale 1ns / 1ps

module aicd_fields (
  input  logic [31:0]    word,
  input  logic [5:0]     cls,
  output aicd_pkg::dec_t dec
);

  logic [3:0]  f_rd;
  logic [3:0]  f_rn;
  logic [3:0]  f_rm;
  logic [3:0]  f_rs;
  logic [3:0]  f_mode;
  logic [4:0]  rot;
  logic [63:0] rot_src;
  logic [31:0] rot_imm;
  logic        is_cmp;
  logic        is_mov;

  assign f_rd   = word[15:12];
  assign f_rn   = word[19:16];
  assign f_rm   = word[3:0];
  assign f_rs   = word[11:8];
  assign f_mode = word[24:21];

  // 8-bit immediate rotated right by twice the rotate field
  assign rot     = {word[11:8], 1'b0};
  assign rot_src = {24'd0, word[7:0], 24'd0, word[7:0]} >> rot;
  assign rot_imm = rot_src[31:0];

  // tst/teq/cmp/cmn have no rd, mov/mvn have no rn
  assign is_cmp = word[24:23] == 2'b10;
  assign is_mov = word[24] && word[23] && word[21];

  always_comb begin
    dec           = '0;
    dec.op_class  = cls;
    dec.cond_code = word[31:28];
    if (cls == aicd_pkg::CLS_BX) begin
      dec.second_reg = f_rm;
    end else if (cls == aicd_pkg::CLS_B || cls == aicd_pkg::CLS_BL) begin
      dec.imm_value = {{6{word[23]}}, word[23:0], 2'b00};
    end else if (cls >= aicd_pkg::CLS_AND && cls <= aicd_pkg::CLS_MVN) begin
      dec.set_flags = word[20];
      if (!is_cmp) dec.dest_reg = f_rd;
      if (!is_mov) dec.base_reg = f_rn;
      if (word[25]) begin
        dec.imm_value = rot_imm;
      end else begin
        dec.reg_operand = 1'b1;
        dec.second_reg  = f_rm;
        dec.shift_kind  = word[6:5];
        if (word[4]) dec.shift_reg = f_rs;
        else dec.shift_amount = word[11:7];
      end
    end else if (cls == aicd_pkg::CLS_MRS) begin
      dec.dest_reg  = f_rd;
      dec.mode_bits = f_mode;
    end else if (cls == aicd_pkg::CLS_MSR) begin
      dec.second_reg  = f_rm;
      dec.reg_operand = 1'b1;
      dec.mode_bits   = f_mode;
    end else if (cls == aicd_pkg::CLS_MSR_FLG) begin
      dec.mode_bits = f_mode;
      if (word[25]) begin
        dec.imm_value = rot_imm;
      end else begin
        dec.second_reg  = f_rm;
        dec.reg_operand = 1'b1;
      end
    end else if (cls == aicd_pkg::CLS_MUL || cls == aicd_pkg::CLS_MLA) begin
      dec.dest_reg   = f_rn;
      if (cls == aicd_pkg::CLS_MLA) dec.base_reg = f_rd;
      dec.second_reg = f_rm;
      dec.shift_reg  = f_rs;
      dec.set_flags  = word[20];
    end else if (cls >= aicd_pkg::CLS_SMULL && cls <= aicd_pkg::CLS_UMLAL) begin
      dec.dest_reg   = f_rn;
      dec.base_reg   = f_rd;
      dec.second_reg = f_rm;
      dec.shift_reg  = f_rs;
      dec.set_flags  = word[20];
    end else if (cls == aicd_pkg::CLS_LDR || cls == aicd_pkg::CLS_STR) begin
      dec.dest_reg  = f_rd;
      dec.base_reg  = f_rn;
      dec.set_flags = word[20];
      dec.mode_bits = f_mode;
      if (word[25]) begin
        dec.reg_operand  = 1'b1;
        dec.second_reg   = f_rm;
        dec.shift_kind   = word[6:5];
        dec.shift_amount = word[11:7];
      end else begin
        dec.imm_value = {20'd0, word[11:0]};
      end
    end else if (cls >= aicd_pkg::CLS_LDRH && cls <= aicd_pkg::CLS_LDRSH) begin
      dec.dest_reg  = f_rd;
      dec.base_reg  = f_rn;
      dec.set_flags = word[20];
      dec.mode_bits = f_mode;
      if (word[22]) begin
        dec.imm_value = {24'd0, f_rs, f_rm};
      end else begin
        dec.reg_operand = 1'b1;
        dec.second_reg  = f_rm;
      end
    end else if (cls == aicd_pkg::CLS_LDM || cls == aicd_pkg::CLS_STM) begin
      dec.base_reg  = f_rn;
      dec.set_flags = word[20];
      dec.mode_bits = f_mode;
      dec.imm_value = {16'd0, word[15:0]};
    end else if (cls == aicd_pkg::CLS_SWP || cls == aicd_pkg::CLS_SWPB) begin
      dec.dest_reg   = f_rd;
      dec.base_reg   = f_rn;
      dec.second_reg = f_rm;
    end else if (cls == aicd_pkg::CLS_SWI) begin
      dec.imm_value = {8'd0, word[23:0]};
    end else if (cls == aicd_pkg::CLS_CDP) begin
      dec.dest_reg   = f_rd;
      dec.base_reg   = f_rn;
      dec.second_reg = f_rm;
      dec.shift_reg  = f_rs;
      dec.imm_value  = {25'd0, word[23:20], word[7:5]};
    end else if (cls == aicd_pkg::CLS_LDC || cls == aicd_pkg::CLS_STC) begin
      dec.dest_reg  = f_rd;
      dec.base_reg  = f_rn;
      dec.shift_reg = f_rs;
      dec.set_flags = word[20];
      dec.mode_bits = f_mode;
      dec.imm_value = {22'd0, word[7:0], 2'b00};
    end else if (cls == aicd_pkg::CLS_MRC || cls == aicd_pkg::CLS_MCR) begin
      dec.dest_reg   = f_rd;
      dec.base_reg   = f_rn;
      dec.second_reg = f_rm;
      dec.shift_reg  = f_rs;
      dec.set_flags  = word[20];
      dec.imm_value  = {26'd0, word[23:21], word[7:5]};
    end
  end

endmodule

>>> rtl/core/aicd_checker.sv
`timescale 1ns / 1ps

module aicd_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [5:0]  op_class,
  input logic [3:0]  dest_reg,
  input logic [3:0]  base_reg,
  input logic [3:0]  second_reg,
  input logic [3:0]  shift_reg,
  input logic        set_flags,
  input logic [31:0] imm_value,
  input logic        reg_operand,
  input logic [1:0]  shift_kind,
  input logic [4:0]  shift_amount,
  input logic [3:0]  mode_bits
);

  // a stalled result word stays valid and holds its class and immediate
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(op_class) && $stable(imm_value))
    else $error("stalled result word changed");

  // undefined words carry only the condition
  a_undef_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && op_class == aicd_pkg::CLS_UNDEF |->
      dest_reg == 4'd0 && base_reg == 4'd0 && second_reg == 4'd0 && shift_reg == 4'd0 &&
      !set_flags && imm_value == 32'd0 && !reg_operand && shift_kind == 2'd0 &&
      shift_amount == 5'd0 && mode_bits == 4'd0)
    else $error("undefined word has nonzero fields");

  // shift kind and amount only go with a register operand
  a_shift_regop: assert property (@(posedge clk) disable iff (rst)
    out_valid && !reg_operand |-> shift_kind == 2'd0 && shift_amount == 5'd0)
    else $error("shift fields without register operand");

  // class code stays in range
  a_class_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> op_class <= aicd_pkg::CLS_UNDEF)
    else $error("class code out of range");

endmodule

bind arm_instruction_class_decoder aicd_checker u_aicd_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (dec.valid),
  .out_ready    (dec.ready),
  .op_class     (dec.op_class),
  .dest_reg     (dec.dest_reg),
  .base_reg     (dec.base_reg),
  .second_reg   (dec.second_reg),
  .shift_reg    (dec.shift_reg),
  .set_flags    (dec.set_flags),
  .imm_value    (dec.imm_value),
  .reg_operand  (dec.reg_operand),
  .shift_kind   (dec.shift_kind),
  .shift_amount (dec.shift_amount),
  .mode_bits    (dec.mode_bits)
);

>>> tb/arm_instruction_class_decoder_tb.sv
`timescale 1ns / 1ps

module arm_instruction_class_decoder_tb;
  import aicd_pkg::*;

  localparam int RANDOM_WORDS = 1075;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 80;
  localparam int MAX_REPORTS  = 100;

  // hand-picked words: field extremes, one of most classes, and the odd corners
  localparam int DIRECTED_COUNT = 26;
  localparam logic [31:0] DIRECTED_WORDS [DIRECTED_COUNT] = '{
    32'h0000_0000,  // and, all fields zero
    32'hffff_ffff,  // condition never, lands on swi
    32'he12f_ff1e,  // bx lr
    32'hea7f_ffff,  // b, largest forward offset
    32'heb80_0000,  // bl, largest backward offset
    32'he031_0392,  // mla with s
    32'he0f1_0392,  // smlal with s
    32'he141_2093,  // swpb
    32'he1d0_10b4,  // ldrh immediate offset
    32'he190_10f4,  // ldrsh register offset
    32'he120_0090,  // extension space, not a known form
    32'he14f_0000,  // mrs from spsr
    32'he129_f001,  // msr register
    32'he328_f4ff,  // msr flags, rotated immediate
    32'he3a0_0fff,  // mov, rotate by 30
    32'he091_0312,  // add, register-shifted register
    32'he1e0_0fe8,  // mvn, ror by 31
    32'he140_0002,  // cmp without s
    32'he700_0010,  // 011x with bit 4 set
    32'he7b1_2103,  // ldr, shifted register offset, writeback
    32'he8fd_8001,  // ldm with user bank bit
    32'hef12_3456,  // swi
    32'hee01_2345,  // cdp
    32'heddf_10ff,  // ldc, largest offset
    32'hee11_0f10,  // mrc
    32'hee01_0f10   // mcr
  };

  // mask and pattern pairs used to shape random words into each class
  localparam int SHAPE_COUNT = 34;
  localparam logic [63:0] SHAPES [SHAPE_COUNT] = '{
    64'h0fff_fff0_012f_ff10, 64'h0f00_0000_0a00_0000, 64'h0f00_0000_0b00_0000,
    64'h0fe0_00f0_0000_0090, 64'h0fe0_00f0_0020_0090, 64'h0fe0_00f0_0080_0090,
    64'h0fe0_00f0_00a0_0090, 64'h0fe0_00f0_00c0_0090, 64'h0fe0_00f0_00e0_0090,
    64'h0ff0_0ff0_0100_0090, 64'h0ff0_0ff0_0140_0090, 64'h0e10_00f0_0010_00b0,
    64'h0e10_00f0_0000_00b0, 64'h0e10_00f0_0010_00d0, 64'h0e10_00f0_0010_00f0,
    64'h0e00_0090_0000_0090, 64'h0fbf_0fff_010f_0000, 64'h0fbf_fff0_0129_f000,
    64'h0d3f_f000_0128_f000, 64'h0c00_0000_0000_0000, 64'h0c00_0000_0000_0000,
    64'h0d90_0000_0100_0000, 64'h0e00_0010_0600_0010, 64'h0c10_0000_0410_0000,
    64'h0c10_0000_0400_0000, 64'h0e10_0000_0810_0000, 64'h0e10_0000_0800_0000,
    64'h0f00_0000_0f00_0000, 64'h0f00_0010_0e00_0000, 64'h0e10_0000_0c10_0000,
    64'h0e10_0000_0c00_0000, 64'h0f10_0010_0e10_0010, 64'h0f10_0010_0e00_0010,
    64'h0e00_0000_0200_0000
  };

  // expected decodes, checked in order
  class decode_scoreboard;
    localparam logic [3:0] OP_TST = 4'h8;
    localparam logic [3:0] OP_CMN = 4'hb;
    localparam logic [3:0] OP_MOV = 4'hd;
    localparam logic [3:0] OP_MVN = 4'hf;

    dec_t pending_decodes[$];
    int   err_count;

    function new();
      err_count = 0;
    endfunction

    function int pending();
      return pending_decodes.size();
    endfunction

    function logic [31:0] rot_imm(logic [31:0] w);
      logic [63:0] t;
      t = {24'b0, w[7:0], 24'b0, w[7:0]} >> {w[11:8], 1'b0};
      return t[31:0];
    endfunction

    function dec_t decode_word(logic [31:0] w);
      dec_t       d;
      logic [5:0] cls;
      logic [3:0] op;
      op = w[24:21];
      // first matching pattern wins
      if ((w & 32'h0fff_fff0) == 32'h012f_ff10) cls = CLS_BX;
      else if ((w & 32'h0f00_0000) == 32'h0a00_0000) cls = CLS_B;
      else if ((w & 32'h0f00_0000) == 32'h0b00_0000) cls = CLS_BL;
      else if ((w & 32'h0fe0_00f0) == 32'h0000_0090) cls = CLS_MUL;
      else if ((w & 32'h0fe0_00f0) == 32'h0020_0090) cls = CLS_MLA;
      else if ((w & 32'h0fe0_00f0) == 32'h0080_0090) cls = CLS_UMULL;
      else if ((w & 32'h0fe0_00f0) == 32'h00a0_0090) cls = CLS_UMLAL;
      else if ((w & 32'h0fe0_00f0) == 32'h00c0_0090) cls = CLS_SMULL;
      else if ((w & 32'h0fe0_00f0) == 32'h00e0_0090) cls = CLS_SMLAL;
      else if ((w & 32'h0ff0_0ff0) == 32'h0100_0090) cls = CLS_SWP;
      else if ((w & 32'h0ff0_0ff0) == 32'h0140_0090) cls = CLS_SWPB;
      else if ((w & 32'h0e10_00f0) == 32'h0010_00b0) cls = CLS_LDRH;
      else if ((w & 32'h0e10_00f0) == 32'h0000_00b0) cls = CLS_STRH;
      else if ((w & 32'h0e10_00f0) == 32'h0010_00d0) cls = CLS_LDRSB;
      else if ((w & 32'h0e10_00f0) == 32'h0010_00f0) cls = CLS_LDRSH;
      else if ((w & 32'h0e00_0090) == 32'h0000_0090) cls = CLS_UNDEF;
      else if ((w & 32'h0fbf_0fff) == 32'h010f_0000) cls = CLS_MRS;
      else if ((w & 32'h0fbf_fff0) == 32'h0129_f000) cls = CLS_MSR;
      else if ((w & 32'h0d3f_f000) == 32'h0128_f000) cls = CLS_MSR_FLG;
      else if ((w & 32'h0c00_0000) == 32'h0000_0000)
        cls = (op >= OP_TST && op <= OP_CMN && !w[20]) ? CLS_UNDEF : CLS_AND + {2'b00, op};
      else if ((w & 32'h0e00_0010) == 32'h0600_0010) cls = CLS_UNDEF;
      else if ((w & 32'h0c10_0000) == 32'h0410_0000) cls = CLS_LDR;
      else if ((w & 32'h0c10_0000) == 32'h0400_0000) cls = CLS_STR;
      else if ((w & 32'h0e10_0000) == 32'h0810_0000) cls = CLS_LDM;
      else if ((w & 32'h0e10_0000) == 32'h0800_0000) cls = CLS_STM;
      else if ((w & 32'h0f00_0000) == 32'h0f00_0000) cls = CLS_SWI;
      else if ((w & 32'h0f00_0010) == 32'h0e00_0000) cls = CLS_CDP;
      else if ((w & 32'h0e10_0000) == 32'h0c10_0000) cls = CLS_LDC;
      else if ((w & 32'h0e10_0000) == 32'h0c00_0000) cls = CLS_STC;
      else if ((w & 32'h0f10_0010) == 32'h0e10_0010) cls = CLS_MRC;
      else if ((w & 32'h0f10_0010) == 32'h0e00_0010) cls = CLS_MCR;
      else cls = CLS_UNDEF;

      // unused fields stay zero
      d = '0;
      d.op_class  = cls;
      d.cond_code = w[31:28];
      if (cls == CLS_BX) begin
        d.second_reg = w[3:0];
      end else if (cls == CLS_B || cls == CLS_BL) begin
        d.imm_value = {{6{w[23]}}, w[23:0], 2'b00};
      end else if (cls >= CLS_AND && cls <= CLS_MVN) begin
        d.set_flags = w[20];
        if (!(op >= OP_TST && op <= OP_CMN)) d.dest_reg = w[15:12];
        if (op != OP_MOV && op != OP_MVN) d.base_reg = w[19:16];
        if (w[25]) begin
          d.imm_value = rot_imm(w);
        end else begin
          d.reg_operand = 1'b1;
          d.second_reg  = w[3:0];
          d.shift_kind  = w[6:5];
          // shift by register or by immediate amount
          if (w[4]) d.shift_reg = w[11:8];
          else d.shift_amount = w[11:7];
        end
      end else if (cls == CLS_MRS) begin
        d.dest_reg  = w[15:12];
        d.mode_bits = w[24:21];
      end else if (cls == CLS_MSR) begin
        d.second_reg  = w[3:0];
        d.reg_operand = 1'b1;
        d.mode_bits   = w[24:21];
      end else if (cls == CLS_MSR_FLG) begin
        d.mode_bits = w[24:21];
        if (w[25]) begin
          d.imm_value = rot_imm(w);
        end else begin
          d.second_reg  = w[3:0];
          d.reg_operand = 1'b1;
        end
      end else if (cls == CLS_MUL || cls == CLS_MLA) begin
        d.dest_reg = w[19:16];
        if (cls == CLS_MLA) d.base_reg = w[15:12];
        d.second_reg = w[3:0];
        d.shift_reg  = w[11:8];
        d.set_flags  = w[20];
      end else if (cls >= CLS_SMULL && cls <= CLS_UMLAL) begin
        d.dest_reg   = w[19:16];
        d.base_reg   = w[15:12];
        d.second_reg = w[3:0];
        d.shift_reg  = w[11:8];
        d.set_flags  = w[20];
      end else if (cls == CLS_LDR || cls == CLS_STR) begin
        d.dest_reg  = w[15:12];
        d.base_reg  = w[19:16];
        d.set_flags = w[20];
        d.mode_bits = w[24:21];
        if (w[25]) begin
          d.reg_operand  = 1'b1;
          d.second_reg   = w[3:0];
          d.shift_kind   = w[6:5];
          d.shift_amount = w[11:7];
        end else begin
          d.imm_value = {20'b0, w[11:0]};
        end
      end else if (cls >= CLS_LDRH && cls <= CLS_LDRSH) begin
        d.dest_reg  = w[15:12];
        d.base_reg  = w[19:16];
        d.set_flags = w[20];
        d.mode_bits = w[24:21];
        if (w[22]) begin
          d.imm_value = {24'b0, w[11:8], w[3:0]};
        end else begin
          d.reg_operand = 1'b1;
          d.second_reg  = w[3:0];
        end
      end else if (cls == CLS_LDM || cls == CLS_STM) begin
        d.base_reg  = w[19:16];
        d.set_flags = w[20];
        d.mode_bits = w[24:21];
        d.imm_value = {16'b0, w[15:0]};
      end else if (cls == CLS_SWP || cls == CLS_SWPB) begin
        d.dest_reg   = w[15:12];
        d.base_reg   = w[19:16];
        d.second_reg = w[3:0];
      end else if (cls == CLS_SWI) begin
        d.imm_value = {8'b0, w[23:0]};
      end else if (cls == CLS_CDP) begin
        d.dest_reg   = w[15:12];
        d.base_reg   = w[19:16];
        d.second_reg = w[3:0];
        d.shift_reg  = w[11:8];
        // opcode nibble sits just above the three info bits
        d.imm_value  = {25'b0, w[23:20], 3'b000} | {29'b0, w[7:5]};
      end else if (cls == CLS_LDC || cls == CLS_STC) begin
        d.dest_reg  = w[15:12];
        d.base_reg  = w[19:16];
        d.shift_reg = w[11:8];
        d.set_flags = w[20];
        d.mode_bits = w[24:21];
        d.imm_value = {22'b0, w[7:0], 2'b00};
      end else if (cls == CLS_MRC || cls == CLS_MCR) begin
        d.dest_reg   = w[15:12];
        d.base_reg   = w[19:16];
        d.second_reg = w[3:0];
        d.shift_reg  = w[11:8];
        d.set_flags  = w[20];
        d.imm_value  = {26'b0, w[23:21], w[7:5]};
      end
      return d;
    endfunction

    function void note_word(logic [31:0] w);
      pending_decodes.insert(pending_decodes.size(), decode_word(w));
    endfunction

    function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      end
    endfunction

    function void check_result(dec_t got);
      dec_t want;
      if (pending_decodes.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $error("decoded word with no instruction outstanding, op_class 0x%0h", got.op_class);
        return;
      end
      want = pending_decodes.pop_front();
      cmp_field("op_class", 32'(want.op_class), 32'(got.op_class));
      cmp_field("cond_code", 32'(want.cond_code), 32'(got.cond_code));
      cmp_field("dest_reg", 32'(want.dest_reg), 32'(got.dest_reg));
      cmp_field("base_reg", 32'(want.base_reg), 32'(got.base_reg));
      cmp_field("second_reg", 32'(want.second_reg), 32'(got.second_reg));
      cmp_field("shift_reg", 32'(want.shift_reg), 32'(got.shift_reg));
      cmp_field("set_flags", 32'(want.set_flags), 32'(got.set_flags));
      cmp_field("imm_value", want.imm_value, got.imm_value);
      cmp_field("reg_operand", 32'(want.reg_operand), 32'(got.reg_operand));
      cmp_field("shift_kind", 32'(want.shift_kind), 32'(got.shift_kind));
      cmp_field("shift_amount", 32'(want.shift_amount), 32'(got.shift_amount));
      cmp_field("mode_bits", 32'(want.mode_bits), 32'(got.mode_bits));
    endfunction
  endclass

  logic clk;
  logic rst;

  aicd_in_if  inst_ch ();
  aicd_out_if dec_ch ();

  arm_instruction_class_decoder dut (
    .clk  (clk),
    .rst  (rst),
    .inst (inst_ch),
    .dec  (dec_ch)
  );

  decode_scoreboard sb = new();
  int quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // random word, mostly shaped into one class with random content
  function automatic logic [31:0] shaped_word();
    int          k;
    logic [31:0] r;
    r = $urandom;
    if ($urandom_range(0, 9) < 2) return r;
    k = $urandom_range(0, SHAPE_COUNT - 1);
    return (r & ~SHAPES[k][63:32]) | SHAPES[k][31:0];
  endfunction

  // offer one word and hold it until taken
  task automatic send_word(input logic [31:0] w);
    inst_ch.valid      <= 1'b1;
    inst_ch.instr_word <= w;
    do @(posedge clk); while (!inst_ch.ready);
  endtask

  // sender gap with junk on the bus
  task automatic idle_sender(input int cycles);
    inst_ch.valid      <= 1'b0;
    inst_ch.instr_word <= $urandom;
    repeat (cycles) @(posedge clk);
  endtask

  // stop offering until every decode has come back
  task automatic wait_drained();
    inst_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // monitor: note accepted words, check accepted decodes, watch for a hang
  always @(posedge clk) begin
    dec_t got;
    if (!rst) begin
      got.op_class     = dec_ch.op_class;
      got.cond_code    = dec_ch.cond_code;
      got.dest_reg     = dec_ch.dest_reg;
      got.base_reg     = dec_ch.base_reg;
      got.second_reg   = dec_ch.second_reg;
      got.shift_reg    = dec_ch.shift_reg;
      got.set_flags    = dec_ch.set_flags;
      got.imm_value    = dec_ch.imm_value;
      got.reg_operand  = dec_ch.reg_operand;
      got.shift_kind   = dec_ch.shift_kind;
      got.shift_amount = dec_ch.shift_amount;
      got.mode_bits    = dec_ch.mode_bits;
      if (inst_ch.valid && inst_ch.ready) sb.note_word(inst_ch.instr_word);
      if (dec_ch.valid && dec_ch.ready) sb.check_result(got);
    end
    if ((inst_ch.valid && inst_ch.ready) || (dec_ch.valid && dec_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("arm_instruction_class_decoder_tb failed");
        $finish;
      end
    end
  end

  // receiver: segments of steady, sparse, dense or toggling ready, with long holds
  initial begin
    int seg;
    int mode;
    int len;
    dec_ch.ready <= 1'b0;
    seg = 0;
    @(posedge clk);
    forever begin
      if (seg % 8 == 3) begin
        dec_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 3);
        len  = $urandom_range(10, 60);
        repeat (len) begin
          case (mode)
            0: dec_ch.ready <= 1'b1;
            1: dec_ch.ready <= ($urandom_range(0, 3) != 0);
            2: dec_ch.ready <= ($urandom_range(0, 4) == 0);
            default: dec_ch.ready <= ~dec_ch.ready;
          endcase
          @(posedge clk);
        end
      end
      seg++;
    end
  end

  // stimulus
  initial begin
    int  sent;
    int  burst;
    bit  paused;
    inst_ch.valid      <= 1'b0;
    inst_ch.instr_word <= '0;
    rst                <= 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_WORDS[i]) send_word(DIRECTED_WORDS[i]);
    wait_drained();

    // bursts of shaped words with random gaps, one full drain halfway
    sent   = 0;
    paused = 1'b0;
    while (sent < RANDOM_WORDS) begin
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst && sent < RANDOM_WORDS; i++) begin
        send_word(shaped_word());
        sent++;
      end
      if (!paused && sent >= RANDOM_WORDS / 2) begin
        paused = 1'b1;
        wait_drained();
      end else if ($urandom_range(0, 3) != 0) begin
        idle_sender($urandom_range(1, 12));
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.err_count == 0 && sb.pending() == 0) begin
      $display("arm_instruction_class_decoder_tb passed");
    end else begin
      $display("arm_instruction_class_decoder_tb failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/aicd_pkg.sv
rtl/core/aicd_in_if.sv
rtl/core/aicd_out_if.sv
rtl/core/aicd_classify.sv
rtl/core/aicd_fields.sv
rtl/core/arm_instruction_class_decoder.sv
rtl/core/aicd_checker.sv
tb/arm_instruction_class_decoder_tb.sv
